// ===== sv/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// Shared request codes, status codes, field widths and the result struct
// of the positional list engine.
// ----------------------------------------------------------------------------
package plst_pkg;

  // field widths of one item and one result
  localparam int REQ_W   = 4;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 2;
  localparam int SIZE_W  = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd4;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_ROTL       = 4'd6;
  localparam logic [REQ_W-1:0] REQ_ROTR       = 4'd7;
  localparam logic [REQ_W-1:0] REQ_REVERSE    = 4'd8;
  localparam logic [REQ_W-1:0] REQ_MIDDLE     = 4'd9;
  localparam logic [REQ_W-1:0] REQ_MOVE       = 4'd10;
  localparam logic [REQ_W-1:0] REQ_SWAP       = 4'd11;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // one finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    logic [STAT_W-1:0]         status;
    logic [SIZE_W-1:0]         size;
  } result_t;

endpackage

// ===== sv/positional_list_engine_unit.sv =====
// Sequence: a failed check or a request that changes nothing goes straight to the
//   result; a push writes once, pop and middle read once; insert, remove and move
//   shift elements (move also writes the held one), rotate first reduces modulo count.
// Only one item is in flight: the next is accepted after the result is handed on;
//   each element moved takes a read and a write.
// Reset: clears count, head and output valid; RAM contents stay undefined.
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed 32-bit values with positional insert, remove,
// rotate, reverse, move and swap, held as a circular buffer in RAM.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [plst_pkg::REQ_W-1:0]          req_type,
  input  logic signed [plst_pkg::VALUE_W-1:0] item_value,
  input  logic [plst_pkg::POS_W-1:0]          position,
  input  logic [plst_pkg::POS_W-1:0]          second_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plst_pkg::VALUE_W-1:0] result_value,
  output logic                                value_valid,
  output logic [plst_pkg::STAT_W-1:0]         status,
  output logic [plst_pkg::SIZE_W-1:0]         list_size
);

  logic idle, done, slot_free, start;
  plst_pkg::result_t result;

  assign in_stall  = !idle;
  assign start     = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  plst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .req_type        (req_type),
    .item_value      (item_value),
    .position        (position),
    .second_position (second_position),
    .slot_free       (slot_free),
    .idle            (idle),
    .done            (done),
    .result          (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result_value <= result.value;
      value_valid  <= result.valid;
      status       <= result.status;
      list_size    <= result.size;
    end
  end

  // a result is only handed over when the output slot can take it
  a_done_slot: assert property (@(posedge clk) disable iff (rst) done |-> slot_free)
    else $error("result finished while output slot busy");

  // an accepted item keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst) start |=> in_stall)
    else $error("block idle right after accepting an item");

  // a result without an element carries a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !value_valid) |-> (result_value == '0))
    else $error("nonzero value without value_valid");

endmodule

// ===== sv/plst_ram.sv =====
// ----------------------------------------------------------------------------
// plst_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/plst_ctrl.sv =====
// ----------------------------------------------------------------------------
// plst_ctrl
// Request sequencer: keeps head and count of a circular list held in RAM,
// checks each request, then walks the RAM one read or write per cycle.
// ----------------------------------------------------------------------------
module plst_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [plst_pkg::REQ_W-1:0]          req_type,
  input  logic signed [plst_pkg::VALUE_W-1:0] item_value,
  input  logic [plst_pkg::POS_W-1:0]          position,
  input  logic [plst_pkg::POS_W-1:0]          second_position,
  input  logic                                slot_free,
  output logic                                idle,
  output logic                                done,
  output plst_pkg::result_t                   result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PLAN, S_DIV, S_GET_RD, S_GET_WT, S_SH_RD, S_SH_WR, S_PUT,
    S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_FIN
  } state_t;

  state_t state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [plst_pkg::REQ_W-1:0] req;
  logic [plst_pkg::POS_W-1:0] p1;
  logic [plst_pkg::POS_W-1:0] p2;
  logic [CW-1:0] rd_idx, wr_idx, put_idx, get_idx, sw_a, sw_b, steps;
  logic up, rot, do_put, keep, adv;
  logic [PW-1:0] rem;
  logic [plst_pkg::VALUE_W-1:0] hold, hold_a, res;
  logic vld;
  logic [plst_pkg::STAT_W-1:0] st;

  logic [PW-1:0] nx, p1x, p2x;
  logic [CW-1:0] i1, i2, rot_t, rot_k;
  logic is_full, is_empty, p1_bad, p2_bad, ins_bad;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [plst_pkg::VALUE_W-1:0] wdata, rdata;

  // logical index to RAM address, wrapping around the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] h);
    return (h == AW'(CAPACITY - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [AW-1:0] head_dec(input logic [AW-1:0] h);
    return (h == '0) ? AW'(CAPACITY - 1) : h - 1'b1;
  endfunction

  // request checks
  assign nx       = PW'(count);
  assign p1x      = PW'(p1);
  assign p2x      = PW'(p2);
  assign i1       = CW'(p1x - 1'b1);
  assign i2       = CW'(p2x - 1'b1);
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);
  assign p1_bad   = (p1x == '0) || (p1x > nx);
  assign p2_bad   = (p2x == '0) || (p2x > nx);
  assign ins_bad  = (p1x == '0) || (p1x > nx + 1'b1);

  // rotation amount after the modulo, as a left rotation
  assign rot_t = CW'(rem);
  assign rot_k = (req == plst_pkg::REQ_ROTL || rot_t == '0) ? rot_t : count - rot_t;

  // ram port drive
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = '0;
    waddr = '0;
    wdata = hold;
    case (state)
      S_GET_RD: begin
        re    = 1'b1;
        raddr = phys(head, get_idx);
      end
      S_SH_RD: begin
        re    = 1'b1;
        raddr = phys(head, rd_idx);
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = phys(head, wr_idx);
        wdata = rdata;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = phys(head, put_idx);
      end
      S_SW_RA: begin
        re    = 1'b1;
        raddr = phys(head, sw_a);
      end
      S_SW_RB: begin
        re    = 1'b1;
        raddr = phys(head, sw_b);
      end
      S_SW_WA: begin
        we    = 1'b1;
        waddr = phys(head, sw_a);
        wdata = rdata;
      end
      S_SW_WB: begin
        we    = 1'b1;
        waddr = phys(head, sw_b);
        wdata = hold_a;
      end
      default: begin
      end
    endcase
  end

  plst_ram #(
    .WIDTH (plst_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= req_type;
            hold  <= item_value;
            p1    <= position;
            p2    <= second_position;
            state <= S_PLAN;
          end
        end

        S_PLAN: begin
          st     <= plst_pkg::ST_OK;
          res    <= '0;
          vld    <= 1'b0;
          do_put <= 1'b0;
          keep   <= 1'b0;
          adv    <= 1'b0;
          rot    <= 1'b0;
          steps  <= '0;
          state  <= S_FIN;
          case (req)
            plst_pkg::REQ_PUSH_FRONT, plst_pkg::REQ_PUSH_BACK: begin
              if (is_full) begin
                st <= plst_pkg::ST_FULL;
              end else begin
                if (req == plst_pkg::REQ_PUSH_FRONT) begin
                  head    <= head_dec(head);
                  put_idx <= '0;
                end else begin
                  put_idx <= count;
                end
                count  <= count + 1'b1;
                do_put <= 1'b1;
                state  <= S_PUT;
              end
            end
            plst_pkg::REQ_INSERT: begin
              if (is_full) begin
                st <= plst_pkg::ST_FULL;
              end else if (ins_bad) begin
                st <= plst_pkg::ST_RANGE;
              end else begin
                rd_idx  <= count - 1'b1;
                wr_idx  <= count;
                up      <= 1'b0;
                steps   <= count - i1;
                put_idx <= i1;
                do_put  <= 1'b1;
                count   <= count + 1'b1;
                state   <= (count != i1) ? S_SH_RD : S_PUT;
              end
            end
            plst_pkg::REQ_POP_FRONT, plst_pkg::REQ_POP_BACK, plst_pkg::REQ_MIDDLE: begin
              if (is_empty) begin
                st <= plst_pkg::ST_EMPTY;
              end else begin
                if (req == plst_pkg::REQ_POP_FRONT) begin
                  get_idx <= '0;
                  adv     <= 1'b1;
                  count   <= count - 1'b1;
                end else if (req == plst_pkg::REQ_POP_BACK) begin
                  get_idx <= count - 1'b1;
                  count   <= count - 1'b1;
                end else begin
                  get_idx <= count >> 1;
                end
                state <= S_GET_RD;
              end
            end
            plst_pkg::REQ_REMOVE: begin
              if (is_empty) begin
                st <= plst_pkg::ST_EMPTY;
              end else if (p1_bad) begin
                st <= plst_pkg::ST_RANGE;
              end else begin
                get_idx <= i1;
                rd_idx  <= i1 + 1'b1;
                wr_idx  <= i1;
                up      <= 1'b1;
                steps   <= count - 1'b1 - i1;
                count   <= count - 1'b1;
                state   <= S_GET_RD;
              end
            end
            plst_pkg::REQ_ROTL, plst_pkg::REQ_ROTR: begin
              if (is_empty) begin
                st <= plst_pkg::ST_EMPTY;
              end else begin
                rem   <= p1x;
                state <= S_DIV;
              end
            end
            plst_pkg::REQ_REVERSE: begin
              sw_a  <= '0;
              sw_b  <= count - 1'b1;
              steps <= count >> 1;
              state <= (count > CW'(1)) ? S_SW_RA : S_FIN;
            end
            plst_pkg::REQ_MOVE: begin
              if (is_empty) begin
                st <= plst_pkg::ST_EMPTY;
              end else if (p1_bad || p2_bad) begin
                st <= plst_pkg::ST_RANGE;
              end else begin
                get_idx <= i1;
                keep    <= 1'b1;
                do_put  <= 1'b1;
                put_idx <= i2;
                wr_idx  <= i1;
                if (i1 < i2) begin
                  rd_idx <= i1 + 1'b1;
                  up     <= 1'b1;
                  steps  <= i2 - i1;
                end else begin
                  rd_idx <= i1 - 1'b1;
                  up     <= 1'b0;
                  steps  <= i1 - i2;
                end
                state <= S_GET_RD;
              end
            end
            plst_pkg::REQ_SWAP: begin
              if (is_empty) begin
                st <= plst_pkg::ST_EMPTY;
              end else if (p1_bad || p2_bad) begin
                st <= plst_pkg::ST_RANGE;
              end else begin
                sw_a  <= i1;
                sw_b  <= i2;
                steps <= CW'(1);
                state <= S_SW_RA;
              end
            end
            default: begin
            end
          endcase
        end

        // rotate amount modulo count by repeated subtraction
        S_DIV: begin
          if (rem >= nx) begin
            rem <= rem - nx;
          end else begin
            rd_idx <= '0;
            wr_idx <= count;
            rot    <= 1'b1;
            steps  <= rot_k;
            state  <= (rot_k != '0) ? S_SH_RD : S_FIN;
          end
        end

        S_GET_RD: begin
          state <= S_GET_WT;
        end

        S_GET_WT: begin
          if (keep) begin
            hold <= rdata;
          end else begin
            res <= rdata;
            vld <= 1'b1;
          end
          state <= (steps != '0) ? S_SH_RD : (do_put ? S_PUT : S_FIN);
        end

        S_SH_RD: begin
          state <= S_SH_WR;
        end

        // one element moved; rotation moves the front to the back
        S_SH_WR: begin
          if (rot) begin
            head <= head_inc(head);
          end else if (up) begin
            rd_idx <= rd_idx + 1'b1;
            wr_idx <= wr_idx + 1'b1;
          end else begin
            rd_idx <= rd_idx - 1'b1;
            wr_idx <= wr_idx - 1'b1;
          end
          steps <= steps - 1'b1;
          state <= (steps != CW'(1)) ? S_SH_RD : (do_put ? S_PUT : S_FIN);
        end

        S_PUT: begin
          state <= S_FIN;
        end

        S_SW_RA: begin
          state <= S_SW_RB;
        end

        S_SW_RB: begin
          hold_a <= rdata;
          state  <= S_SW_WA;
        end

        S_SW_WA: begin
          state <= S_SW_WB;
        end

        S_SW_WB: begin
          sw_a  <= sw_a + 1'b1;
          sw_b  <= sw_b - 1'b1;
          steps <= steps - 1'b1;
          state <= (steps != CW'(1)) ? S_SW_RA : S_FIN;
        end

        S_FIN: begin
          if (slot_free) begin
            if (adv) begin
              head <= head_inc(head);
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result hand-off
  assign idle          = (state == S_IDLE);
  assign done          = (state == S_FIN) && slot_free;
  assign result.value  = res;
  assign result.valid  = vld;
  assign result.status = st;
  assign result.size   = plst_pkg::SIZE_W'(count);

endmodule

// ===== sim/tb_positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine. A table of directed
// requests covers empty and range errors and the unused codes. A long
// run of random requests follows, with the list driven through growth,
// shrink and mixed spells. Every result is checked against its table row or
// an in-bench model of the list, with random bursts and gaps on the input
// side and random stalls on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_positional_list_engine_unit;

  localparam int CAP        = 16;
  localparam int RAND_ITEMS = 430;
  localparam int DRAIN_WAIT = 200;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_AT    = 120;
  localparam int PAUSE_AT   = 260;

  typedef logic [plst_pkg::REQ_W-1:0]          req_t;
  typedef logic signed [plst_pkg::VALUE_W-1:0] val_t;
  typedef logic [plst_pkg::POS_W-1:0]          pos_t;

  localparam req_t REQ_SPARE_LO = 4'd12;
  localparam req_t REQ_SPARE_HI = 4'd15;

  // list growth spells for the random part
  typedef enum int {SPELL_GROW, SPELL_SHRINK, SPELL_MIX} spell_t;

  typedef struct {
    req_t              req;
    val_t              val;
    pos_t              pos;
    pos_t              pos2;
    bit                typed;
    plst_pkg::result_t res;
  } dir_row_t;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_stall;
  req_t                               req_type;
  val_t                               item_value;
  pos_t                               position;
  pos_t                               second_position;
  logic                               out_valid;
  logic                               out_stall;
  val_t                               result_value;
  logic                               value_valid;
  logic [plst_pkg::STAT_W-1:0]        status;
  logic [plst_pkg::SIZE_W-1:0]        list_size;

  // model of the list contents
  val_t list_cells[CAP];
  int   list_len;

  plst_pkg::result_t pending_results[$];
  dir_row_t          dir_rows[$];
  int                items_sent;
  int                results_seen;
  int                mismatches;
  int                hold_left;
  bit                hold_done;
  int                stall_mode;
  int                stall_cnt;
  int                full_hits;

  positional_list_engine_unit #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .item_value(item_value),
    .position(position), .second_position(second_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .value_valid(value_valid),
    .status(status), .list_size(list_size)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // shift helpers for the list model
  function automatic void list_put(int idx, val_t v);
    for (int i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
    list_cells[idx] = v;
    list_len++;
  endfunction

  function automatic val_t list_take(int idx);
    val_t v;
    v = list_cells[idx];
    for (int i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
    list_len--;
    return v;
  endfunction

  // apply one request to the list model and return its result
  function automatic plst_pkg::result_t list_apply(req_t req, val_t val,
                                                   pos_t p1, pos_t p2);
    plst_pkg::result_t r;
    val_t              tmp[CAP];
    val_t              t;
    int                n;
    int                k;
    n = list_len;
    r = '0;
    r.status = plst_pkg::ST_OK;
    case (req)
      plst_pkg::REQ_PUSH_FRONT, plst_pkg::REQ_PUSH_BACK, plst_pkg::REQ_INSERT: begin
        if (n >= CAP) begin
          r.status = plst_pkg::ST_FULL;
          full_hits++;
        end else if (req == plst_pkg::REQ_PUSH_FRONT) list_put(0, val);
        else if (req == plst_pkg::REQ_PUSH_BACK) list_put(n, val);
        else if (p1 < 1 || p1 > n + 1) r.status = plst_pkg::ST_RANGE;
        else list_put(p1 - 1, val);
      end
      plst_pkg::REQ_POP_FRONT, plst_pkg::REQ_POP_BACK, plst_pkg::REQ_REMOVE: begin
        if (n == 0) r.status = plst_pkg::ST_EMPTY;
        else if (req == plst_pkg::REQ_POP_FRONT) begin
          r.value = list_take(0);
          r.valid = 1'b1;
        end else if (req == plst_pkg::REQ_POP_BACK) begin
          r.value = list_take(n - 1);
          r.valid = 1'b1;
        end else if (p1 < 1 || p1 > n) r.status = plst_pkg::ST_RANGE;
        else begin
          r.value = list_take(p1 - 1);
          r.valid = 1'b1;
        end
      end
      plst_pkg::REQ_ROTL, plst_pkg::REQ_ROTR: begin
        if (n == 0) r.status = plst_pkg::ST_EMPTY;
        else begin
          k = p1 % n;
          if (req == plst_pkg::REQ_ROTR) k = (n - k) % n;
          for (int i = 0; i < n; i++) tmp[i] = list_cells[(i + k) % n];
          for (int i = 0; i < n; i++) list_cells[i] = tmp[i];
        end
      end
      plst_pkg::REQ_REVERSE: begin
        for (int i = 0; i < n / 2; i++) begin
          t = list_cells[i];
          list_cells[i] = list_cells[n-1-i];
          list_cells[n-1-i] = t;
        end
      end
      plst_pkg::REQ_MIDDLE: begin
        if (n == 0) r.status = plst_pkg::ST_EMPTY;
        else begin
          r.value = list_cells[n/2];
          r.valid = 1'b1;
        end
      end
      plst_pkg::REQ_MOVE, plst_pkg::REQ_SWAP: begin
        if (n == 0) r.status = plst_pkg::ST_EMPTY;
        else if (p1 < 1 || p1 > n || p2 < 1 || p2 > n) r.status = plst_pkg::ST_RANGE;
        else if (req == plst_pkg::REQ_MOVE) begin
          t = list_take(p1 - 1);
          list_put(p2 - 1, t);
        end else begin
          t = list_cells[p1-1];
          list_cells[p1-1] = list_cells[p2-1];
          list_cells[p2-1] = t;
        end
      end
      default: ;
    endcase
    r.size = list_len[plst_pkg::SIZE_W-1:0];
    return r;
  endfunction

  function automatic plst_pkg::result_t mk_res(val_t v, logic vv,
                                               logic [plst_pkg::STAT_W-1:0] st, int sz);
    plst_pkg::result_t r;
    r.value = v;
    r.valid = vv;
    r.status = st;
    r.size = sz[plst_pkg::SIZE_W-1:0];
    return r;
  endfunction

  function automatic void add_row(req_t req, val_t val, int p1, int p2, bit typed,
                                  plst_pkg::result_t r);
    dir_row_t d;
    d.req = req;
    d.val = val;
    d.pos = p1[plst_pkg::POS_W-1:0];
    d.pos2 = p2[plst_pkg::POS_W-1:0];
    d.typed = typed;
    d.res = r;
    dir_rows = {dir_rows, d};
  endfunction

  // offer one item and hold it until accepted, then record its expectation
  task automatic send_item(req_t req, val_t val, pos_t p1, pos_t p2,
                           bit typed, plst_pkg::result_t typed_res);
    plst_pkg::result_t r;
    in_valid <= 1'b1;
    req_type <= req;
    item_value <= val;
    position <= p1;
    second_position <= p2;
    do @(posedge clk); while (in_stall);
    r = list_apply(req, val, p1, p2);
    pending_results = {pending_results, (typed ? typed_res : r)};
    items_sent++;
  endtask

  // random gap after an item, ending a burst now and then
  task automatic maybe_gap(inout int burst_left);
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    plst_pkg::result_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result value=%0d size=%0d", $realtime,
                     result_value, list_size);
        end else begin
          exp_r = pending_results[0];
          pending_results.delete(0);
          if (result_value !== exp_r.value || value_valid !== exp_r.valid ||
              status !== exp_r.status || list_size !== exp_r.size) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch exp v=%0d vv=%0b st=%0d sz=%0d got v=%0d vv=%0b st=%0d sz=%0d",
                       $realtime, exp_r.value, exp_r.valid, exp_r.status, exp_r.size,
                       result_value, value_valid, status, list_size);
          end
        end
      end
      // long hold-off once, otherwise a changing stall pattern
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      stall_cnt++;
      if (stall_cnt >= 32) begin
        stall_cnt = 0;
        stall_mode = $urandom_range(0, 2);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // stimulus
  initial begin
    spell_t   spell;
    int       burst_left;
    int       pick;
    int       limit;
    req_t     req;
    pos_t     p1;
    pos_t     p2;
    dir_row_t d;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    req_type = '0;
    item_value = '0;
    position = '0;
    second_position = '0;
    list_len = 0;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    hold_left = 0;
    hold_done = 1'b0;
    stall_mode = 0;
    stall_cnt = 0;
    full_hits = 0;
    burst_left = 1;
    for (int i = 0; i < CAP; i++) list_cells[i] = '0;

    // directed table: empty list errors, extremes, range errors, each op
    add_row(plst_pkg::REQ_POP_FRONT, 0, 0, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_EMPTY, 0));
    add_row(plst_pkg::REQ_ROTL, 0, 3, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_EMPTY, 0));
    add_row(plst_pkg::REQ_REVERSE, 0, 0, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_OK, 0));
    add_row(plst_pkg::REQ_MIDDLE, 0, 0, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_EMPTY, 0));
    add_row(plst_pkg::REQ_MOVE, 0, 1, 1, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_EMPTY, 0));
    add_row(REQ_SPARE_LO, 0, 0, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_OK, 0));
    add_row(plst_pkg::REQ_PUSH_BACK, 32'sh7fffffff, 0, 0, 1'b1,
            mk_res(0, 1'b0, plst_pkg::ST_OK, 1));
    add_row(plst_pkg::REQ_PUSH_FRONT, 32'sh80000000, 0, 0, 1'b1,
            mk_res(0, 1'b0, plst_pkg::ST_OK, 2));
    add_row(plst_pkg::REQ_INSERT, 9, 0, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_RANGE, 2));
    add_row(plst_pkg::REQ_INSERT, 9, 4, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_RANGE, 2));
    add_row(plst_pkg::REQ_INSERT, -1, 3, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_OK, 3));
    add_row(plst_pkg::REQ_INSERT, 5, 1, 0, 1'b0, '0);
    add_row(plst_pkg::REQ_MIDDLE, 0, 0, 0, 1'b0, '0);
    add_row(plst_pkg::REQ_ROTL, 0, 31, 0, 1'b0, '0);
    add_row(plst_pkg::REQ_ROTR, 0, 17, 0, 1'b0, '0);
    add_row(plst_pkg::REQ_REVERSE, 0, 0, 0, 1'b0, '0);
    add_row(plst_pkg::REQ_SWAP, 0, 2, 2, 1'b0, '0);
    add_row(plst_pkg::REQ_SWAP, 0, 1, 4, 1'b0, '0);
    add_row(plst_pkg::REQ_MOVE, 0, 4, 1, 1'b0, '0);
    add_row(plst_pkg::REQ_MOVE, 0, 2, 5, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_RANGE, 4));
    add_row(plst_pkg::REQ_REMOVE, 0, 0, 0, 1'b1, mk_res(0, 1'b0, plst_pkg::ST_RANGE, 4));
    add_row(plst_pkg::REQ_REMOVE, 0, 4, 0, 1'b0, '0);
    add_row(plst_pkg::REQ_POP_BACK, 0, 0, 0, 1'b0, '0);
    add_row(plst_pkg::REQ_POP_FRONT, 0, 0, 0, 1'b0, '0);
    add_row(REQ_SPARE_HI, -1, 31, 31, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      send_item(d.req, d.val, d.pos, d.pos2, d.typed, d.res);
      maybe_gap(burst_left);
    end

    // random requests in spells of growth, shrinking and mixing
    spell = SPELL_GROW;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) spell = spell_t'($urandom_range(0, 2));
      if (items_sent == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (spell == SPELL_GROW)
        req = (pick < 60) ? req_t'($urandom_range(0, 2)) : req_t'($urandom_range(3, 11));
      else if (spell == SPELL_SHRINK)
        req = (pick < 50) ? req_t'($urandom_range(3, 5)) : req_t'($urandom_range(0, 11));
      else
        req = (pick < 4) ? req_t'($urandom_range(12, 15)) : req_t'($urandom_range(0, 11));
      limit = (req == plst_pkg::REQ_INSERT) ? list_len + 1 : list_len;
      if ($urandom_range(0, 4) == 0 || limit == 0) begin
        p1 = pos_t'($urandom_range(0, 31));
        p2 = pos_t'($urandom_range(0, 31));
      end else begin
        p1 = pos_t'($urandom_range(1, limit));
        p2 = pos_t'($urandom_range(1, limit));
      end
      send_item(req, $urandom, p1, p2, 1'b0, '0);
      maybe_gap(burst_left);
    end
    in_valid <= 1'b0;

    limit = 0;
    while (pending_results.size() != 0 && limit < 100000) begin
      @(posedge clk);
      limit++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d requests, %0d results checked, full list reached %0d times",
             items_sent, results_seen, full_hits);
    $display("directed table of %0d rows plus random spells with long output hold-off",
             dir_rows.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #4ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
